>>> design/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude unit.
package sgm_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int MAG_BITS       = 11;
   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 4;
   localparam int ROOT_BITS      = 11;
   localparam int RAD_BITS       = 2 * ROOT_BITS;
   localparam int SUM_BITS       = PIXEL_BITS + 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
   localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = CFG_BITS'(1024);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  pad;
   } req_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] magnitude;
      logic                frame_last;
   } rsp_type;

endpackage

>>> design/sgm_line_mem.sv
// Line buffer RAM: one write port, one read port with registered read data.
module sgm_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 16
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_BITS-1:0]       rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data
);

   logic [DATA_BITS-1:0] line_ram [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sgm_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module sgm_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sgm_pkg::RAD_BITS-1:0]    radicand,
   output logic                            done,
   output logic [sgm_pkg::ROOT_BITS-1:0]   root
);

   localparam int RAD       = sgm_pkg::RAD_BITS;
   localparam int ROOT      = sgm_pkg::ROOT_BITS;
   localparam int REM_BITS  = ROOT + 2;
   localparam int STEP_BITS = $clog2(ROOT);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [RAD-1:0]       rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT-1:0]      root_ff, root_in;

   logic [REM_BITS+1:0]  rem_shift;
   logic [REM_BITS-1:0]  trial;
   logic [REM_BITS+1:0]  rem_diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, rad_ff[RAD-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rem_diff  = rem_shift - {2'b00, trial};
      fits      = rem_shift >= {2'b00, trial};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(ROOT - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD-3:0], 2'b00};
         if (fits) begin
            rem_in  = rem_diff[REM_BITS-1:0];
            root_in = {root_ff[ROOT-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[REM_BITS-1:0];
            root_in = {root_ff[ROOT-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> design/sobel_gradient_magnitude_unit.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream with line buffer RAM.
//
//   port group | dir | handshake          | payload
//   req_       | in  | req_valid/req_stall | sgm_pkg::req_type (pixel, pad)
//   rsp_       | out | rsp_valid/rsp_stall | sgm_pkg::rsp_type (magnitude, frame_last)
//   csr_       | in  | csr_valid/csr_ready | csr_index, csr_wdata
//
// One transaction at a time: an item without a result is accepted, then does the line
// RAM read-modify-write; an item with a result then also passes the gradient state, the
// squaring states SQX and SQY and the 11-step square-root unit before the output state.
// Synchronous reset clears state, counters, window and output valid; the line RAM is not cleared.
// A stalled result waits in the output register while the next item is accepted.
// csr_ready only with no item in flight; a pending write stalls req_, and one to a mapped index restarts the frame.
module sobel_gradient_magnitude_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  sgm_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sgm_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sgm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sgm_pkg::CFG_BITS-1:0]           csr_wdata
);

   localparam int PB        = sgm_pkg::PIXEL_BITS;
   localparam int CFG       = sgm_pkg::CFG_BITS;
   localparam int SUM       = sgm_pkg::SUM_BITS;
   localparam int RAD       = sgm_pkg::RAD_BITS;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int CMP_BITS  = (COL_BITS + 1 > CFG + 1) ? COL_BITS + 1 : CFG + 1;
   localparam logic [CMP_BITS-1:0] WIDTH_MAX = CMP_BITS'(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQX,
      ST_SQY,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef logic [2:0][PB-1:0] column_type;

   function automatic logic [SUM-1:0] wsum(input logic [PB-1:0] a, b, c);
      return SUM'(a) + (SUM'(b) << 1) + SUM'(c);
   endfunction

   function automatic logic [SUM-1:0] absdiff(input logic [SUM-1:0] a, b);
      return (a >= b) ? a - b : b - a;
   endfunction

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sgm_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [CFG-1:0]        width_ff, width_in;
   logic [CFG-1:0]        height_ff, height_in;
   logic [CFG-1:0]        row_ff, row_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [PB-1:0]         pix_ff, pix_in;
   column_type [2:0]      win_ff, win_in;
   logic                  sel_left_ff, sel_left_in;
   logic                  sel_right_ff, sel_right_in;
   logic                  last_ff, last_in;
   logic [SUM-1:0]        abs_gx_ff, abs_gx_in;
   logic [SUM-1:0]        abs_gy_ff, abs_gy_in;
   logic [RAD-1:0]        sq_ff, sq_in;

   logic [CMP_BITS-1:0]   w_raw, w_eff, col_next;
   logic [CFG-1:0]        h_eff, h_plus1;
   logic                  last_pos, emit, row_lt_h, row_is_one;
   logic                  req_accept, csr_write;

   logic [2*PB-1:0]       mem_rd_data;
   logic                  mem_wr_en;
   logic [2*PB-1:0]       mem_wr_data;
   logic [PB-1:0]         above, mid, below, top;

   column_type            left_col, center_col, right_col;
   logic [2*SUM-1:0]      gx_sq, gy_sq;

   logic                  sqrt_start, sqrt_done;
   logic [sgm_pkg::ROOT_BITS-1:0] sqrt_root;

   // effective frame size
   always_comb begin
      w_raw = CMP_BITS'(width_ff);
      if (width_ff == '0) begin
         w_eff = CMP_BITS'(1);
      end else if (w_raw > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = w_raw;
      end
      if (height_ff == '0) begin
         h_eff = CFG'(1);
      end else if (height_ff > sgm_pkg::HEIGHT_LIMIT) begin
         h_eff = sgm_pkg::HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
   end

   assign h_plus1    = h_eff + 1'b1;
   assign col_next   = CMP_BITS'(col_ff) + 1'b1;
   assign last_pos   = (row_ff == h_plus1) && (col_ff == '0);
   assign emit       = (row_ff >= CFG'(2)) || ((row_ff == CFG'(1)) && (col_ff != '0));
   assign row_lt_h   = row_ff < h_eff;
   assign row_is_one = row_ff == CFG'(1);

   // a waiting register write goes first
   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = state_ff == ST_IDLE;
   assign csr_write  = csr_valid && csr_ready;

   // line RAM word: upper half is the row above, lower half the current row
   assign above       = mem_rd_data[2*PB-1:PB];
   assign mid         = mem_rd_data[PB-1:0];
   assign below       = row_lt_h ? pix_ff : mid;
   assign top         = row_is_one ? mid : above;
   assign mem_wr_en   = state_ff == ST_READ;
   assign mem_wr_data = {mid, below};

   sgm_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * PB)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (col_ff),
      .wr_data (mem_wr_data)
   );

   // replicate the center column at the left and right image edges
   assign left_col   = sel_left_ff ? win_ff[1] : win_ff[0];
   assign center_col = win_ff[1];
   assign right_col  = sel_right_ff ? win_ff[1] : win_ff[2];

   assign gx_sq = (2*SUM)'(abs_gx_ff) * (2*SUM)'(abs_gx_ff);
   assign gy_sq = (2*SUM)'(abs_gy_ff) * (2*SUM)'(abs_gy_ff);

   assign sqrt_start = state_ff == ST_SQY;

   sgm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_in),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pix_in       = pix_ff;
      win_in       = win_ff;
      sel_left_in  = sel_left_ff;
      sel_right_in = sel_right_ff;
      last_in      = last_ff;
      abs_gx_in    = abs_gx_ff;
      abs_gy_in    = abs_gy_ff;
      sq_in        = sq_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pix_in   = req_data.pixel;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            win_in[0]    = win_ff[1];
            win_in[1]    = win_ff[2];
            win_in[2]    = {below, mid, top};
            sel_left_in  = (col_ff == COL_BITS'(1))
                           || ((col_ff == '0) && (w_eff == CMP_BITS'(1)));
            sel_right_in = col_ff == '0;
            last_in      = last_pos;
            // advance the raster position; the final flush item restarts the frame
            if (last_pos) begin
               row_in = '0;
               col_in = '0;
            end else if (col_next >= w_eff) begin
               row_in = row_ff + 1'b1;
               col_in = '0;
            end else begin
               col_in = col_next[COL_BITS-1:0];
            end
            state_in = emit ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            abs_gx_in = absdiff(wsum(right_col[0], right_col[1], right_col[2]),
                                wsum(left_col[0], left_col[1], left_col[2]));
            abs_gy_in = absdiff(wsum(left_col[2], center_col[2], right_col[2]),
                                wsum(left_col[0], center_col[0], right_col[0]));
            state_in  = ST_SQX;
         end
         ST_SQX: begin
            sq_in    = RAD'(gx_sq);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in    = sq_ff + RAD'(gy_sq);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.magnitude  = sqrt_root;
               rsp_data_in.frame_last = last_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            sgm_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               row_in   = '0;
               col_in   = '0;
            end
            sgm_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               row_in    = '0;
               col_in    = '0;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sgm_pkg::WIDTH_RESET;
         height_ff <= sgm_pkg::HEIGHT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         win_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         win_ff    <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      sel_left_ff  <= sel_left_in;
      sel_right_ff <= sel_right_in;
      last_ff      <= last_in;
      abs_gx_ff    <= abs_gx_in;
      abs_gy_ff    <= abs_gy_in;
      sq_ff        <= sq_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   col_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(col_ff) < w_eff)
      else $error("column counter beyond image width");

   row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_plus1)
      else $error("row counter beyond flush row");

   root_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_WAIT)
      else $error("square root finished outside wait state");

   result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into output register");

endmodule

>>> tb/tb_sobel_gradient_magnitude_unit.sv
// Self-checking testbench for the Sobel gradient magnitude unit.
module tb_sobel_gradient_magnitude_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_WIDTH           = 1024;
   localparam int unsigned RANDOM_ITEMS        = 150;
   localparam int unsigned DEFAULT_PROBE_ITEMS = 649;
   localparam int unsigned SETTLE_CYCLES       = 24;
   localparam int unsigned LONG_HOLD           = 400;
   localparam int unsigned WATCHDOG_LIMIT      = 4000;
   localparam int unsigned FULL_FRAME          = 32'hFFFF_FFFF;
   localparam logic [sgm_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = '1;

   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_RAMP, FILL_CORNER} fill_type;

   // Predicts the magnitude stream and checks the results against it in order.
   class magnitude_scoreboard;
      // [0] top, [1] middle, [2] bottom
      typedef bit [2:0][sgm_pkg::PIXEL_BITS-1:0] column_type;

      bit [sgm_pkg::CFG_BITS-1:0]   width_reg;
      bit [sgm_pkg::CFG_BITS-1:0]   height_reg;
      bit [sgm_pkg::PIXEL_BITS-1:0] upper_line [MAX_WIDTH];
      bit [sgm_pkg::PIXEL_BITS-1:0] recent_line [MAX_WIDTH];
      column_type                   columns [3];             // [0] oldest .. [2] newest
      bit [sgm_pkg::CFG_BITS-1:0]   row_index;
      int unsigned                  col_index;
      sgm_pkg::rsp_type             expected_magnitudes [$];
      int unsigned                  mismatch_count;
      int unsigned                  checked_count;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            recent_line[i] = '0;
         end
         foreach (columns[i]) columns[i] = '0;
         width_reg      = sgm_pkg::WIDTH_RESET;
         height_reg     = sgm_pkg::HEIGHT_RESET;
         row_index      = '0;
         col_index      = 0;
         mismatch_count = 0;
         checked_count  = 0;
      endfunction

      function void note_config(logic [sgm_pkg::CSR_INDEX_BITS-1:0] index,
                                logic [sgm_pkg::CFG_BITS-1:0] value);
         if (index == sgm_pkg::CSR_IMAGE_WIDTH) width_reg = value;
         else if (index == sgm_pkg::CSR_IMAGE_HEIGHT) height_reg = value;
         else return;
         row_index = '0;
         col_index = 0;
      endfunction

      function int unsigned gradient_magnitude(column_type lhs, column_type mid_col,
                                               column_type rhs);
         int gx, gy, energy;
         int unsigned root, trial;
         gx = (int'(rhs[0]) + 2 * int'(rhs[1]) + int'(rhs[2]))
            - (int'(lhs[0]) + 2 * int'(lhs[1]) + int'(lhs[2]));
         gy = (int'(lhs[2]) + 2 * int'(mid_col[2]) + int'(rhs[2]))
            - (int'(lhs[0]) + 2 * int'(mid_col[0]) + int'(rhs[0]));
         energy = gx * gx + gy * gy;
         root = 0;
         for (int b = sgm_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= energy) root = trial;
         end
         return root;
      endfunction

      function void accept_pixel(sgm_pkg::req_type item);
         int unsigned w, h, col, n, last_n;
         bit fires;
         bit [sgm_pkg::PIXEL_BITS-1:0] top, middle, bottom;
         sgm_pkg::rsp_type res;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         h = height_reg;
         if (h < 1) h = 1;
         if (h > sgm_pkg::HEIGHT_LIMIT) h = sgm_pkg::HEIGHT_LIMIT;
         if (col_index >= w) col_index = 0;
         col    = col_index;
         n      = row_index * w + col;
         last_n = w * h + w;
         fires  = (n >= w + 1) && (n <= last_n);
         // flush rows repeat the last image row
         middle = recent_line[col];
         bottom = (row_index < h) ? item.pixel : middle;
         top    = (row_index == 1) ? middle : upper_line[col];
         res = '0;
         // column 0 closes the previous row: replicate its last column on the right
         if (col == 0 && fires)
            res.magnitude = sgm_pkg::MAG_BITS'(gradient_magnitude(
               (w == 1) ? columns[2] : columns[1], columns[2], columns[2]));
         columns[0] = columns[1];
         columns[1] = columns[2];
         columns[2] = {bottom, middle, top};
         if (col != 0 && fires)
            res.magnitude = sgm_pkg::MAG_BITS'(gradient_magnitude(
               (col == 1) ? columns[1] : columns[0], columns[1], columns[2]));
         upper_line[col]  = middle;
         recent_line[col] = bottom;
         if (fires && n == last_n) begin
            row_index = '0;
            col_index = 0;
         end else begin
            col_index = col + 1;
            if (col_index >= w) begin
               col_index = 0;
               row_index = row_index + 1'b1;
            end
         end
         if (fires) begin
            res.frame_last = (n == last_n);
            expected_magnitudes.push_back(res);
         end
      endfunction

      task report(string what);
         // keep the log short on a broken design; count everything
         if (mismatch_count < 100) $display("ERROR: %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_magnitude(sgm_pkg::rsp_type got);
         sgm_pkg::rsp_type want;
         checked_count++;
         if (expected_magnitudes.size() == 0) begin
            report($sformatf("unexpected result magnitude %0d frame_last %b",
                             got.magnitude, got.frame_last));
         end else begin
            want = expected_magnitudes.pop_front();
            if (got.magnitude !== want.magnitude)
               report($sformatf("magnitude %0d, expected %0d", got.magnitude, want.magnitude));
            if (got.frame_last !== want.frame_last)
               report($sformatf("frame_last %b, expected %b", got.frame_last, want.frame_last));
         end
      endtask
   endclass

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   sgm_pkg::req_type                   req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   sgm_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [sgm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sgm_pkg::CFG_BITS-1:0]       csr_wdata = '0;

   magnitude_scoreboard magnitudes;
   logic [sgm_pkg::CFG_BITS-1:0] cfg_width  = sgm_pkg::WIDTH_RESET;
   logic [sgm_pkg::CFG_BITS-1:0] cfg_height = sgm_pkg::HEIGHT_RESET;
   int unsigned items_accepted = 0;
   int unsigned frames_sent    = 0;
   int unsigned csr_writes     = 0;
   int unsigned long_holds     = 0;
   bit          steady         = 1'b0;
   bit          hold_request   = 1'b0;

   sobel_gradient_magnitude_unit #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned effective(logic [sgm_pkg::CFG_BITS-1:0] value,
                                             int unsigned ceiling);
      if (value < 1) return 1;
      if (value > ceiling) return ceiling;
      return value;
   endfunction

   function automatic logic [sgm_pkg::PIXEL_BITS-1:0] pick_pixel(fill_type fill,
                                                                  int unsigned row,
                                                                  int unsigned col);
      case (fill)
         FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
         FILL_RAMP:    return sgm_pkg::PIXEL_BITS'(row * 29 + col * 47);
         FILL_CORNER:  return (col >= row) ? '1 : '0;
         default:      return sgm_pkg::PIXEL_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input sgm_pkg::req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      magnitudes.accept_pixel(item);
      items_accepted++;
   endtask

   // Hold the input until every expected magnitude is back and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (magnitudes.expected_magnitudes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sgm_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [sgm_pkg::CFG_BITS-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      magnitudes.note_config(index, value);
      if (index == sgm_pkg::CSR_IMAGE_WIDTH) cfg_width = value;
      else if (index == sgm_pkg::CSR_IMAGE_HEIGHT) cfg_height = value;
      csr_writes++;
   endtask

   // Send items first..stop-1 of a frame: image rows, then width+1 flush items.
   task automatic send_frame(input fill_type fill, input int unsigned first,
                             input int unsigned stop);
      int unsigned w, h, total;
      sgm_pkg::req_type item;
      w = effective(cfg_width, MAX_WIDTH);
      h = effective(cfg_height, sgm_pkg::HEIGHT_LIMIT);
      total = w * h + w + 1;
      if (stop < total) total = stop;
      for (int unsigned i = first; i < total; i++) begin
         if (i < w * h) begin
            item.pixel = pick_pixel(fill, i / w, i % w);
            item.pad   = ($urandom_range(0, 9) == 0);
         end else begin
            item.pixel = sgm_pkg::PIXEL_BITS'($urandom_range(0, 255));
            item.pad   = ($urandom_range(0, 7) != 0);
         end
         send_item(item);
      end
      if (total == w * h + w + 1) frames_sent++;
   endtask

   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) magnitudes.check_magnitude(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
            long_holds++;
         end
         if (stall_left == 0 && !steady && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_sobel_gradient_magnitude_unit NOT OK");
      $finish;
   end

   initial begin : stimulus
      logic [sgm_pkg::CFG_BITS-1:0] extreme_w [3];
      logic [sgm_pkg::CFG_BITS-1:0] extreme_h [3];
      int unsigned random_start, kind, r;
      bit restart_pending;
      magnitudes = new();
      extreme_w = '{11'd0, 11'd2, 11'd0};
      extreme_h = '{11'd0, 11'd1, 11'd2};
      restart_pending = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes: a partial 640-wide frame, then restart it by a register write.
      send_frame(FILL_RANDOM, 0, DEFAULT_PROBE_ITEMS);

      write_csr(sgm_pkg::CSR_IMAGE_WIDTH, 11'd3);
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, 11'd3);
      send_frame(FILL_CORNER, 0, FULL_FRAME);

      // An unmapped index mid-frame must neither take effect nor restart the frame.
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, 11'd2);
      send_frame(FILL_RAMP, 0, 3);
      write_csr(CSR_UNMAPPED, '1);
      send_frame(FILL_RAMP, 3, FULL_FRAME);

      write_csr(sgm_pkg::CSR_IMAGE_WIDTH, 11'd1);
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, 11'd1);
      send_frame(FILL_EXTREME, 0, FULL_FRAME);

      // Back-pressure: hold results off while the sender keeps offering.
      write_csr(sgm_pkg::CSR_IMAGE_WIDTH, 11'd6);
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, 11'd5);
      hold_request = 1'b1;
      send_frame(FILL_RANDOM, 0, FULL_FRAME);

      random_start = items_accepted;
      while (items_accepted - random_start < RANDOM_ITEMS) begin
         kind   = $urandom_range(0, 19);
         steady = ($urandom_range(0, 5) == 0);
         if (restart_pending || kind < 14) begin
            if ($urandom_range(0, 2) != 0) begin
               r = $urandom_range(0, 19);
               write_csr(sgm_pkg::CSR_IMAGE_WIDTH, (r == 0) ? 11'd0 :
                         (r < 3) ? sgm_pkg::CFG_BITS'($urandom_range(11, 32)) :
                         sgm_pkg::CFG_BITS'($urandom_range(1, 10)));
            end
            write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ? 11'd0 :
                      sgm_pkg::CFG_BITS'($urandom_range(1, 6)));
            restart_pending = 1'b0;
         end else if (kind == 19) begin
            write_csr(sgm_pkg::CSR_INDEX_BITS'($urandom_range(sgm_pkg::CSR_IMAGE_HEIGHT + 1,
                                                              CSR_UNMAPPED)),
                      sgm_pkg::CFG_BITS'($urandom_range(0, 2047)));
         end
         if (kind == 15 || kind == 16) begin
            // cut the frame short; the next register write restarts it
            send_frame(fill_type'($urandom_range(0, 3)), 0, $urandom_range(1, 40));
            restart_pending = 1'b1;
         end else begin
            send_frame(fill_type'($urandom_range(0, 3)), 0, FULL_FRAME);
         end
      end
      steady = 1'b0;

      // Size extremes, including zero values that clamp.
      foreach (extreme_w[i]) begin
         write_csr(sgm_pkg::CSR_IMAGE_WIDTH, extreme_w[i]);
         write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, extreme_h[i]);
         send_frame(fill_type'($urandom_range(0, 3)), 0, FULL_FRAME);
      end

      drain();
      $display("Sent %0d pixel and flush transactions in %0d complete frames, %0d register writes,",
               items_accepted, frames_sent, csr_writes);
      $display("%0d long result hold-offs; checked %0d magnitudes, %0d mismatches.",
               long_holds, magnitudes.checked_count, magnitudes.mismatch_count);
      if (magnitudes.mismatch_count == 0 && magnitudes.expected_magnitudes.size() == 0)
         $display("tb_sobel_gradient_magnitude_unit OK");
      else
         $display("tb_sobel_gradient_magnitude_unit NOT OK");
      $finish;
   end

endmodule

>>> sobel_gradient_magnitude_unit.f
design/sgm_pkg.sv
design/sgm_line_mem.sv
design/sgm_isqrt.sv
design/sobel_gradient_magnitude_unit.sv
tb/tb_sobel_gradient_magnitude_unit.sv
